FILE: hdl/key_value_table_unit_assert.svh
// Assertion macros for the key-value table.
`ifndef KEY_VALUE_TABLE_UNIT_ASSERT_SVH
`define KEY_VALUE_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define KVT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define KVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define KVT_ASSERT_SAME(label, clk, rst, ante, cons)
`define KVT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/kvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

   localparam int ENTRIES_DEFAULT = 8;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_LOOKUP = 2'd2;

   localparam logic [2:0] STATUS_OK    = 3'd0;
   localparam logic [2:0] STATUS_FULL  = 3'd1;
   localparam logic [2:0] STATUS_DUP   = 3'd2;
   localparam logic [2:0] STATUS_MISS  = 3'd3;
   localparam logic [2:0] STATUS_EMPTY = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RESP
   } kvt_state_type;

   // Search token that walks the cell chain, one cell per cycle.
   typedef struct packed {
      logic        hit;
      logic [31:0] key;
      logic [31:0] value;
      logic [31:0] last_key;
      logic [31:0] last_value;
   } kvt_tok_type;

   // Write-back command broadcast to all cells.
   typedef struct packed {
      logic        ins;
      logic        rem;
      logic [31:0] key;
      logic [31:0] value;
   } kvt_wr_type;

endpackage

`default_nettype wire

FILE: hdl/kvt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface kvt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic signed [31:0] key;
   logic [31:0]        value;

   modport source (output valid, output mode, output key, output value, input ready);
   modport sink (input valid, input mode, input key, input value, output ready);
endinterface

interface kvt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        found;
   logic [31:0] read_value;
   logic [3:0]  fill_count;
   logic        is_full;
   logic        is_empty;

   modport source (output valid, output status, output found, output read_value,
                   output fill_count, output is_full, output is_empty, input ready);
   modport sink (input valid, input status, input found, input read_value,
                 input fill_count, input is_full, input is_empty, output ready);
endinterface

`default_nettype wire

FILE: hdl/kvt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module kvt_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [CNT_W-1:0]     count,
   input  wire logic                 prev_valid,
   input  wire kvt_pkg::kvt_tok_type prev_tok,
   output logic                      next_valid,
   output kvt_pkg::kvt_tok_type      next_tok,
   input  wire kvt_pkg::kvt_wr_type  wr
);

   logic                 valid_ff;
   kvt_pkg::kvt_tok_type tok_ff;
   kvt_pkg::kvt_tok_type tok_in;
   logic                 sel_ff;
   logic                 sel_in;
   logic [31:0]          key_ff;
   logic [31:0]          key_in;
   logic [31:0]          val_ff;
   logic [31:0]          val_in;
   logic                 occupied;
   logic                 is_last;
   logic                 match;

   assign occupied = count > CNT_W'(INDEX);
   assign is_last  = count == CNT_W'(INDEX + 1);
   assign match    = occupied && !prev_tok.hit && (key_ff == prev_tok.key);

   always_comb begin
      tok_in = prev_tok;
      if (match) begin
         tok_in.hit   = 1'b1;
         tok_in.value = val_ff;
      end
      // The cell holding the newest pair hands it along for a remove.
      if (is_last) begin
         tok_in.last_key   = key_ff;
         tok_in.last_value = val_ff;
      end
   end

   always_comb begin
      sel_in = sel_ff;
      if (prev_valid) begin
         sel_in = match;
      end
   end

   always_comb begin
      key_in = key_ff;
      val_in = val_ff;
      if ((wr.ins && (count == CNT_W'(INDEX))) || (wr.rem && sel_ff)) begin
         key_in = wr.key;
         val_in = wr.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= prev_valid;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      key_ff <= key_in;
      val_ff <= val_in;
   end

   assign next_valid = valid_ff;
   assign next_tok   = tok_ff;

endmodule

`default_nettype wire

FILE: hdl/kvt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module kvt_ctrl #(
   parameter int ENTRIES = kvt_pkg::ENTRIES_DEFAULT,
   parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   kvt_req_if.sink                   req_if,
   kvt_rsp_if.source                 rsp_if,
   output logic                      launch_valid,
   output kvt_pkg::kvt_tok_type      launch_tok,
   input  wire logic                 done_valid,
   input  wire kvt_pkg::kvt_tok_type done_tok,
   output kvt_pkg::kvt_wr_type       wr,
   output logic [CNT_W-1:0]          count
);

   kvt_pkg::kvt_state_type state_ff;
   kvt_pkg::kvt_state_type state_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [1:0]             mode_ff;
   logic [1:0]             mode_in;
   logic [31:0]            value_ff;
   logic [31:0]            value_in;
   logic [2:0]             status_ff;
   logic [2:0]             status_in;
   logic                   found_ff;
   logic                   found_in;
   logic [31:0]            rval_ff;
   logic [31:0]            rval_in;
   logic                   accept;
   logic                   full;
   logic                   empty;

   assign full  = count_ff == CNT_W'(ENTRIES);
   assign empty = count_ff == '0;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kvt_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               state_in = kvt_pkg::ST_SEARCH;
            end
         end
         kvt_pkg::ST_SEARCH: begin
            if (done_valid) begin
               state_in = kvt_pkg::ST_RESP;
            end
         end
         kvt_pkg::ST_RESP: begin
            if (rsp_if.ready) begin
               state_in = kvt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kvt_pkg::ST_IDLE;
         end
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_if.ready = 1'b0;
      rsp_if.valid = 1'b0;
      case (state_ff)
         kvt_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
         end
         kvt_pkg::ST_RESP: begin
            rsp_if.valid = 1'b1;
         end
         default: begin
            req_if.ready = 1'b0;
            rsp_if.valid = 1'b0;
         end
      endcase
   end

   assign accept       = req_if.valid && req_if.ready;
   assign launch_valid = accept;

   always_comb begin
      launch_tok            = '0;
      launch_tok.key        = req_if.key;
   end

   always_comb begin
      mode_in  = mode_ff;
      value_in = value_ff;
      if (accept) begin
         mode_in  = req_if.mode;
         value_in = req_if.value;
      end
   end

   // Decision and write-back once the token leaves the last cell.
   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      found_in  = found_ff;
      rval_in   = rval_ff;
      wr        = '0;
      wr.key    = done_tok.key;
      wr.value  = value_ff;
      if ((state_ff == kvt_pkg::ST_SEARCH) && done_valid) begin
         status_in = kvt_pkg::STATUS_OK;
         found_in  = 1'b0;
         rval_in   = '0;
         case (mode_ff)
            kvt_pkg::MODE_INSERT: begin
               found_in = done_tok.hit;
               if (full) begin
                  status_in = kvt_pkg::STATUS_FULL;
               end else if (done_tok.hit) begin
                  status_in = kvt_pkg::STATUS_DUP;
               end else begin
                  wr.ins   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            kvt_pkg::MODE_REMOVE: begin
               if (empty) begin
                  status_in = kvt_pkg::STATUS_EMPTY;
               end else if (!done_tok.hit) begin
                  status_in = kvt_pkg::STATUS_MISS;
               end else begin
                  found_in = 1'b1;
                  wr.rem   = 1'b1;
                  wr.key   = done_tok.last_key;
                  wr.value = done_tok.last_value;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            kvt_pkg::MODE_LOOKUP: begin
               if (empty) begin
                  status_in = kvt_pkg::STATUS_EMPTY;
               end else if (!done_tok.hit) begin
                  status_in = kvt_pkg::STATUS_MISS;
               end else begin
                  found_in = 1'b1;
                  rval_in  = done_tok.value;
               end
            end
            default: begin
               status_in = kvt_pkg::STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kvt_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      rval_ff   <= rval_in;
   end

   assign rsp_if.status     = status_ff;
   assign rsp_if.found      = found_ff;
   assign rsp_if.read_value = rval_ff;
   assign rsp_if.fill_count = 4'(count_ff);
   assign rsp_if.is_full    = full;
   assign rsp_if.is_empty   = empty;
   assign count             = count_ff;

endmodule

`default_nettype wire

FILE: hdl/key_value_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Interface    Role    Beat contents
// req_if    kvt_req_if   sink    mode, key, value
// rsp_if    kvt_rsp_if   source  status, found, read_value, fill_count, is_full, is_empty
//
// From one accept to the next, with rsp_if.ready high, the search token crosses the cell
// chain (the first cell compares in the accept cycle), the decision and write-back are made,
// and the response beat goes out.
// Reset is synchronous and active high; it empties the table (stored pairs are not cleared).
// A stalled response holds its beat, and no new request is taken until it has gone out.

`include "key_value_table_unit_assert.svh"

module key_value_table_unit #(
   parameter int ENTRIES = kvt_pkg::ENTRIES_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   kvt_req_if.sink   req_if,
   kvt_rsp_if.source rsp_if
);

   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic                 tok_valid [0:ENTRIES];
   kvt_pkg::kvt_tok_type tok       [0:ENTRIES];
   kvt_pkg::kvt_wr_type  wr;
   logic [CNT_W-1:0]     count;

   kvt_ctrl #(
      .ENTRIES (ENTRIES),
      .CNT_W   (CNT_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .rsp_if       (rsp_if),
      .launch_valid (tok_valid[0]),
      .launch_tok   (tok[0]),
      .done_valid   (tok_valid[ENTRIES]),
      .done_tok     (tok[ENTRIES]),
      .wr           (wr),
      .count        (count)
   );

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      kvt_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .count      (count),
         .prev_valid (tok_valid[i]),
         .prev_tok   (tok[i]),
         .next_valid (tok_valid[i + 1]),
         .next_tok   (tok[i + 1]),
         .wr         (wr)
      );
   end

   `KVT_ASSERT_SAME(a_one_side_busy, clock, reset, req_if.ready, !rsp_if.valid)
   `KVT_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count <= CNT_W'(ENTRIES))
   `KVT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_if.valid && req_if.ready,
                    !req_if.ready)
   `KVT_ASSERT_SAME(a_done_while_busy, clock, reset, tok_valid[ENTRIES],
                    !req_if.ready && !rsp_if.valid)

endmodule

`default_nettype wire

FILE: tb/sv/tb_key_value_table_unit.sv
`timescale 1ns / 1ps

module tb_key_value_table_unit;
   import kvt_pkg::*;

   localparam int TABLE_DEPTH = ENTRIES_DEFAULT;
   localparam int CLOCK_HALF = 10;
   localparam int RESET_CYCLES = 4;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_ITEMS = 650;
   localparam int POOL_SIZE = 12;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [2:0]  status;
      logic        found;
      logic [31:0] read_value;
      logic [3:0]  fill_count;
      logic        is_full;
      logic        is_empty;
   } table_reply_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kvt_req_if req_ch ();
   kvt_rsp_if rsp_ch ();

   key_value_table_unit #(
      .ENTRIES(TABLE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   // Shadow copy of the table contents, updated in accept order.
   logic [31:0] shadow_keys [TABLE_DEPTH];
   logic [31:0] shadow_values [TABLE_DEPTH];
   int unsigned shadow_count = 0;

   table_reply_t pending_replies [$];
   int error_count = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_off_left = 0;
   bit offering = 1'b0;
   logic [31:0] key_pool [POOL_SIZE];

   logic [31:0] probe_keys [8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                                   32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_8000};
   logic [31:0] probe_values [8] = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
                                     32'h7fff_ffff, 32'h1234_5678, 32'ha5a5_a5a5, 32'h5a5a_5a5a};

   always #(CLOCK_HALF) clock = ~clock;

   // Applies one operation to the shadow table and returns the reply it must produce.
   function automatic table_reply_t compute_table_reply(input logic [1:0] mode,
                                                        input logic [31:0] key,
                                                        input logic [31:0] value);
      table_reply_t reply;
      int slot;
      reply = '0;
      reply.status = STATUS_OK;
      slot = -1;
      for (int i = 0; i < shadow_count; i++) begin
         if (slot < 0 && shadow_keys[i] == key) begin
            slot = i;
         end
      end
      case (mode)
         MODE_INSERT: begin
            // A full table wins over a duplicate, but found still tells presence.
            reply.found = (slot >= 0);
            if (shadow_count >= TABLE_DEPTH) begin
               reply.status = STATUS_FULL;
            end else if (slot >= 0) begin
               reply.status = STATUS_DUP;
            end else begin
               shadow_keys[shadow_count] = key;
               shadow_values[shadow_count] = value;
               shadow_count++;
            end
         end
         MODE_REMOVE: begin
            if (shadow_count == 0) begin
               reply.status = STATUS_EMPTY;
            end else if (slot < 0) begin
               reply.status = STATUS_MISS;
            end else begin
               reply.found = 1'b1;
               shadow_keys[slot] = shadow_keys[shadow_count - 1];
               shadow_values[slot] = shadow_values[shadow_count - 1];
               shadow_count--;
            end
         end
         MODE_LOOKUP: begin
            if (shadow_count == 0) begin
               reply.status = STATUS_EMPTY;
            end else if (slot < 0) begin
               reply.status = STATUS_MISS;
            end else begin
               reply.found = 1'b1;
               reply.read_value = shadow_values[slot];
            end
         end
         default: begin
         end
      endcase
      reply.fill_count = 4'(shadow_count);
      reply.is_full = (shadow_count == TABLE_DEPTH);
      reply.is_empty = (shadow_count == 0);
      return reply;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // Offers one request beat and returns at the edge that accepts it. Valid stays high so
   // that a following beat can go out back to back.
   task automatic send_request(input logic [1:0] mode, input logic [31:0] key,
                               input logic [31:0] value);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         if (offering) begin
            req_ch.valid <= 1'b0;
            offering = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_ch.mode <= mode;
      req_ch.key <= key;
      req_ch.value <= value;
      if (!offering) begin
         req_ch.valid <= 1'b1;
         offering = 1'b1;
      end
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      pending_replies.push_back(compute_table_reply(mode, key, value));
   endtask

   task automatic release_request();
      if (offering) begin
         req_ch.valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   task automatic wait_until_drained();
      release_request();
      @(posedge clock);
      while (pending_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_empty_table();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_request(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      send_request(MODE_REMOVE, 32'h8000_0000, 32'hffff_ffff);
      send_request(MODE_UNUSED, 32'h7fff_ffff, 32'hffff_ffff);
      wait_until_drained();
   endtask

   task automatic test_fill_to_capacity();
      for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
         send_request(MODE_INSERT, probe_keys[i], probe_values[i]);
      end
      send_request(MODE_INSERT, probe_keys[2], 32'hdead_beef);
      send_request(MODE_INSERT, probe_keys[TABLE_DEPTH - 1], probe_values[TABLE_DEPTH - 1]);
      send_request(MODE_INSERT, 32'h1234_5678, 32'h0bad_f00d);
      send_request(MODE_INSERT, probe_keys[0], 32'hffff_ffff);
      wait_until_drained();
   endtask

   task automatic test_lookup_and_remove();
      send_request(MODE_LOOKUP, probe_keys[0], 32'hffff_ffff);
      send_request(MODE_LOOKUP, probe_keys[1], 32'h0000_0000);
      send_request(MODE_LOOKUP, 32'h7fff_fffe, 32'h0000_0000);
      send_request(MODE_UNUSED, probe_keys[3], 32'h0000_0000);
      // Removing a middle slot pulls the last pair into the hole.
      send_request(MODE_REMOVE, probe_keys[2], 32'h0000_0000);
      send_request(MODE_LOOKUP, probe_keys[TABLE_DEPTH - 1], 32'h0000_0000);
      send_request(MODE_REMOVE, probe_keys[2], 32'h0000_0000);
      send_request(MODE_REMOVE, probe_keys[TABLE_DEPTH - 1], 32'h0000_0000);
      wait_until_drained();
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int count);
      bit drain_bias;
      int pick;
      logic [1:0] mode;
      logic [31:0] key;
      logic [31:0] value;
      req_idle_pct = sender_pct;
      rsp_idle_pct = receiver_pct;
      drain_bias = 1'b1;
      // A small pool of keys makes hits, duplicates and a full table common.
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = $urandom;
      end
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            drain_bias = !drain_bias;
         end
         pick = $urandom_range(99);
         if (pick < 4) begin
            mode = MODE_UNUSED;
         end else if (drain_bias) begin
            mode = (pick < 25) ? MODE_INSERT : (pick < 80) ? MODE_REMOVE : MODE_LOOKUP;
         end else begin
            mode = (pick < 55) ? MODE_INSERT : (pick < 75) ? MODE_REMOVE : MODE_LOOKUP;
         end
         key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
         pick = $urandom_range(9);
         value = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hffff_ffff : $urandom;
         send_request(mode, key, value);
      end
      wait_until_drained();
   endtask

   // The receiver holds off for a long stretch while requests keep coming, so the block
   // has to park its response and refuse further requests.
   task automatic test_response_backpressure();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_off_left = HOLD_OFF_CYCLES;
      for (int n = 0; n < 6; n++) begin
         send_request((n % 2 == 0) ? MODE_INSERT : MODE_LOOKUP, key_pool[n], $urandom);
      end
      wait_until_drained();
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.mode <= MODE_INSERT;
      req_ch.key <= '0;
      req_ch.value <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_fill_to_capacity();
      test_lookup_and_remove();
      test_random_traffic(6, 53, RANDOM_ITEMS / 3);
      test_random_traffic(53, 6, RANDOM_ITEMS / 3);
      test_random_traffic(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      test_response_backpressure();
      if (error_count == 0 && pending_replies.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Checks every response beat against the oldest outstanding reply and drives ready.
   initial begin
      table_reply_t want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_replies.size() == 0) begin
               $error("response beat arrived with no request outstanding");
               error_count++;
            end else begin
               want = pending_replies.pop_front();
               check_field("status", want.status, rsp_ch.status);
               check_field("found", want.found, rsp_ch.found);
               check_field("read_value", want.read_value, rsp_ch.read_value);
               check_field("fill_count", want.fill_count, rsp_ch.fill_count);
               check_field("is_full", want.is_full, rsp_ch.is_full);
               check_field("is_empty", want.is_empty, rsp_ch.is_empty);
            end
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/kvt_pkg.sv
hdl/kvt_if.sv
hdl/kvt_cell.sv
hdl/kvt_ctrl.sv
hdl/key_value_table_unit.sv
tb/sv/tb_key_value_table_unit.sv
